[hw/rtl/sem_pkg.sv]
// Shared types and constants for the Sobel edge magnitude unit.
// No dependencies; used by every module of the block except sem_ram.
`default_nettype none

package sem_pkg;

    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam int DIM_MIN     = 3;
    localparam int DIM_RESET   = 2048;

    localparam int PIX_W       = 8;
    localparam int MAG_W       = 8;
    localparam int QUEUE_DEPTH = 4;

    // floor sqrt of a 22-bit sum, one result bit per step
    localparam int SUM_W       = 22;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int ROOT_STEPS  = ROOT_W;

    // 3x3 window handed from front to back; the center pixel is not needed
    typedef struct packed {
        logic [PIX_W-1:0] lt;
        logic [PIX_W-1:0] lm;
        logic [PIX_W-1:0] lb;
        logic [PIX_W-1:0] ct;
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] rt;
        logic [PIX_W-1:0] rm;
        logic [PIX_W-1:0] rb;
        logic             row_last;
        logic             frame_last;
    } win_t;

endpackage

`default_nettype wire

[hw/rtl/sobel_edge_magnitude_unit.sv]
// Top level of the Sobel 3x3 edge magnitude unit.
// Uses sem_pkg, sem_front, sem_fifo and sem_back.
//
//   channel  direction  ports                 contents
//   cfg      in         cfg_wr_en/addr/wdata  0 line_width, 1 frame_height
//   s_       in         tvalid/tready/tdata   pixel; tuser frame_start
//   m_       out        tvalid/tready/tdata   magnitude; tlast row_last,
//                                             tuser frame_last
//
// The front takes one pixel per cycle; only a full window queue stalls it.
// The back end takes each interior window through gradient, square, 11 root
// steps and output load before it pops the next; this sets the interior rate.
// A 4-deep window queue lets the front run ahead of the back.
// aresetn is synchronous; line stores are not cleared and need no clear pass.
`default_nettype none

module sobel_edge_magnitude_unit #(
    parameter int MAX_LINE = 2048,
    parameter int MAX_ROWS = 2048
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [sem_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] pixel
    input  logic                          s_tuser,   // [0] frame_start
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] magnitude
    output logic                          m_tlast,   // row_last
    output logic                          m_tuser    // [0] frame_last
);

    logic          q_push;
    logic          q_ready;
    logic          q_pop;
    logic          q_valid;
    sem_pkg::win_t q_in;
    sem_pkg::win_t q_out;

    sem_front #(
        .MAX_LINE (MAX_LINE),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_pixel       (s_tdata),
        .s_frame_start (s_tuser),
        .q_ready       (q_ready),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    sem_fifo u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_out)
    );

    sem_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (q_valid),
        .pop_data     (q_out),
        .pop          (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_magnitude  (m_tdata),
        .m_row_last   (m_tlast),
        .m_frame_last (m_tuser)
    );

endmodule

`default_nettype wire

[hw/rtl/sem_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hw/rtl/sem_front.sv]
// Front end: config registers, raster counters, line stores and 3x3 window.
// Uses sem_pkg and sem_ram; pushes interior windows into the queue.
`default_nettype none

module sem_front #(
    parameter int MAX_LINE = 2048,
    parameter int MAX_ROWS = 2048
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [sem_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sem_pkg::PIX_W-1:0]     s_pixel,
    input  logic                          s_frame_start,
    input  logic                          q_ready,
    output logic                          q_push,
    output sem_pkg::win_t                 q_data
);

    localparam int CW   = $clog2(MAX_LINE);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int LWW  = $clog2(MAX_LINE + 1);
    localparam int FHW  = $clog2(MAX_ROWS + 1);
    localparam int CMW  = LWW + 1;
    localparam int RMW  = FHW + 1;
    localparam int LW_RESET = (sem_pkg::DIM_RESET > MAX_LINE) ? MAX_LINE : sem_pkg::DIM_RESET;
    localparam int FH_RESET = (sem_pkg::DIM_RESET > MAX_ROWS) ? MAX_ROWS : sem_pkg::DIM_RESET;
    localparam int PW   = sem_pkg::PIX_W;

    logic [LWW-1:0] line_width_reg;
    logic [FHW-1:0] frame_height_reg;
    logic [LWW-1:0] lw_clamp;
    logic [FHW-1:0] fh_clamp;
    logic [31:0]    wdata_ext;

    logic [CW-1:0]  col_reg;
    logic [RW-1:0]  row_reg;
    logic [CW-1:0]  col_cur;
    logic [RW-1:0]  row_cur;
    logic [CMW-1:0] col_inc;
    logic [RMW-1:0] row_inc;
    logic           row_end;
    logic           frame_end;
    logic           interior;

    logic           accept;
    logic           f1_go;
    logic           f1_valid_reg;
    logic [PW-1:0]  f1_pix_reg;
    logic [CW-1:0]  f1_col_reg;
    logic           f1_emit_reg;
    logic           f1_rlast_reg;
    logic           f1_flast_reg;
    logic           fwd_reg;
    logic [PW-1:0]  fwd_top_reg;
    logic [PW-1:0]  fwd_mid_reg;
    logic [PW-1:0]  win_reg [6];

    logic [PW-1:0]  old_rd;
    logic [PW-1:0]  new_rd;
    logic [PW-1:0]  top;
    logic [PW-1:0]  mid;

    // register clamping
    assign wdata_ext = 32'(cfg_wdata);

    always_comb begin
        priority if (wdata_ext < 32'(sem_pkg::DIM_MIN)) begin
            lw_clamp = LWW'(sem_pkg::DIM_MIN);
        end else if (wdata_ext > 32'(MAX_LINE)) begin
            lw_clamp = LWW'(MAX_LINE);
        end else begin
            lw_clamp = LWW'(cfg_wdata);
        end
        priority if (wdata_ext < 32'(sem_pkg::DIM_MIN)) begin
            fh_clamp = FHW'(sem_pkg::DIM_MIN);
        end else if (wdata_ext > 32'(MAX_ROWS)) begin
            fh_clamp = FHW'(MAX_ROWS);
        end else begin
            fh_clamp = FHW'(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LWW'(LW_RESET);
            frame_height_reg <= FHW'(FH_RESET);
        end else if (cfg_wr_en) begin
            if (cfg_addr == sem_pkg::REG_LINE_WIDTH) begin
                line_width_reg <= lw_clamp;
            end
            if (cfg_addr == sem_pkg::REG_FRAME_HEIGHT) begin
                frame_height_reg <= fh_clamp;
            end
        end
    end

    // raster position of the incoming pixel
    assign col_cur   = s_frame_start ? '0 : col_reg;
    assign row_cur   = s_frame_start ? '0 : row_reg;
    assign col_inc   = CMW'(col_cur) + CMW'(1);
    assign row_inc   = RMW'(row_cur) + RMW'(1);
    assign row_end   = col_inc >= CMW'(line_width_reg);
    assign frame_end = row_inc >= RMW'(frame_height_reg);
    assign interior  = (row_cur >= RW'(2)) && (col_cur >= CW'(2));

    assign f1_go    = f1_valid_reg && (!f1_emit_reg || q_ready);
    assign s_tready = !f1_valid_reg || f1_go;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            if (row_end) begin
                col_reg <= '0;
                row_reg <= frame_end ? '0 : row_inc[RW-1:0];
            end else begin
                col_reg <= col_inc[CW-1:0];
                row_reg <= row_cur;
            end
        end
    end

    // line stores: read at accept, written back when the word leaves stage 1
    sem_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_LINE)
    ) u_older_line (
        .aclk    (aclk),
        .wr_en   (f1_go),
        .wr_addr (f1_col_reg),
        .wr_data (mid),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .rd_data (old_rd)
    );

    sem_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_LINE)
    ) u_newer_line (
        .aclk    (aclk),
        .wr_en   (f1_go),
        .wr_addr (f1_col_reg),
        .wr_data (f1_pix_reg),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .rd_data (new_rd)
    );

    // bypass for a read of the column being written in the same cycle
    assign top = fwd_reg ? fwd_top_reg : old_rd;
    assign mid = fwd_reg ? fwd_mid_reg : new_rd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else if (accept) begin
            f1_valid_reg <= 1'b1;
            fwd_reg      <= f1_valid_reg && (f1_col_reg == col_cur);
        end else if (f1_go) begin
            f1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f1_pix_reg   <= s_pixel;
            f1_col_reg   <= col_cur;
            f1_emit_reg  <= interior;
            f1_rlast_reg <= row_end;
            f1_flast_reg <= row_end && frame_end;
            fwd_top_reg  <= mid;
            fwd_mid_reg  <= f1_pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (f1_go) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= f1_pix_reg;
        end
    end

    assign q_push = f1_valid_reg && f1_emit_reg && q_ready;

    always_comb begin
        q_data.lt         = win_reg[0];
        q_data.lm         = win_reg[1];
        q_data.lb         = win_reg[2];
        q_data.ct         = win_reg[3];
        q_data.cb         = win_reg[5];
        q_data.rt         = top;
        q_data.rm         = mid;
        q_data.rb         = f1_pix_reg;
        q_data.row_last   = f1_rlast_reg;
        q_data.frame_last = f1_flast_reg;
    end

`ifndef SYNTHESIS
    a_f1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (f1_valid_reg && !f1_go) |=> (f1_valid_reg && $stable(f1_col_reg)))
        else $error("stage 1 lost or changed a stalled word");

    a_fwd_col0: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg |-> (f1_col_reg == '0))
        else $error("bypass taken away from column zero");
`endif

endmodule

`default_nettype wire

[hw/rtl/sem_fifo.sv]
// Short queue of 3x3 windows between front and back.
// Uses sem_pkg for the window type and depth.
`default_nettype none

module sem_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sem_pkg::win_t push_data,
    output logic          push_ready,
    input  logic          pop,
    output logic          pop_valid,
    output sem_pkg::win_t pop_data
);

    localparam int DEPTH = sem_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sem_pkg::win_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (push |-> (push_ready || pop)) and (pop |-> pop_valid))
        else $error("queue overrun or underrun");
`endif

endmodule

`default_nettype wire

[hw/rtl/sem_back.sv]
// Back end: Sobel gradients, squares and an iterative integer square root.
// Uses sem_pkg; pops windows from the queue, drives the result register.
`default_nettype none

module sem_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      pop_valid,
    input  sem_pkg::win_t             pop_data,
    output logic                      pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [sem_pkg::MAG_W-1:0] m_magnitude,
    output logic                      m_row_last,
    output logic                      m_frame_last
);

    localparam int SW = sem_pkg::SUM_W;
    localparam int RTW = sem_pkg::ROOT_W;
    localparam int REMW = RTW + 3;
    localparam int STW = $clog2(sem_pkg::ROOT_STEPS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SQUARE = 2'd1;
    localparam logic [1:0] ST_ROOT   = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [9:0]        abs_x_reg;
    logic [9:0]        abs_y_reg;
    logic [SW-1:0]     rad_reg;
    logic [REMW-1:0]   rem_reg;
    logic [RTW-1:0]    root_reg;
    logic [STW-1:0]    step_reg;
    logic              rl_reg;
    logic              fl_reg;
    logic              out_valid_reg;
    logic [7:0]        out_mag_reg;
    logic              out_rl_reg;
    logic              out_fl_reg;

    logic [9:0]        sum_xr;
    logic [9:0]        sum_xl;
    logic [9:0]        sum_yb;
    logic [9:0]        sum_yt;
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic [10:0]       gx_mag;
    logic [10:0]       gy_mag;
    logic [19:0]       sq_x;
    logic [19:0]       sq_y;
    logic [REMW-1:0]   rem_try;
    logic [REMW-1:0]   trial;
    logic              fits;
    logic              load_out;
    logic [7:0]        mag_sat;

    // gradients of the popped window
    assign sum_xr = 10'(pop_data.rt) + {1'b0, pop_data.rm, 1'b0} + 10'(pop_data.rb);
    assign sum_xl = 10'(pop_data.lt) + {1'b0, pop_data.lm, 1'b0} + 10'(pop_data.lb);
    assign sum_yb = 10'(pop_data.lb) + {1'b0, pop_data.cb, 1'b0} + 10'(pop_data.rb);
    assign sum_yt = 10'(pop_data.lt) + {1'b0, pop_data.ct, 1'b0} + 10'(pop_data.rt);
    assign gx     = signed'({1'b0, sum_xr}) - signed'({1'b0, sum_xl});
    assign gy     = signed'({1'b0, sum_yb}) - signed'({1'b0, sum_yt});
    assign gx_mag = gx[10] ? 11'(-gx) : 11'(gx);
    assign gy_mag = gy[10] ? 11'(-gy) : 11'(gy);

    assign sq_x = 20'(abs_x_reg) * 20'(abs_x_reg);
    assign sq_y = 20'(abs_y_reg) * 20'(abs_y_reg);

    // one root bit per step
    assign rem_try = {rem_reg[REMW-3:0], rad_reg[SW-1:SW-2]};
    assign trial   = REMW'({root_reg, 2'b01});
    assign fits    = rem_try >= trial;

    assign mag_sat  = (root_reg[RTW-1:1] > (RTW-1)'(255)) ? 8'hFF : root_reg[8:1];
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    assign pop      = (state_reg == ST_IDLE) && pop_valid;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (step_reg == STW'(sem_pkg::ROOT_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            abs_x_reg <= gx_mag[9:0];
            abs_y_reg <= gy_mag[9:0];
            rl_reg    <= pop_data.row_last;
            fl_reg    <= pop_data.frame_last;
        end
        if (state_reg == ST_SQUARE) begin
            rad_reg  <= SW'(sq_x) + SW'(sq_y);
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= '0;
        end else if (state_reg == ST_ROOT) begin
            rad_reg  <= {rad_reg[SW-3:0], 2'b00};
            rem_reg  <= fits ? (rem_try - trial) : rem_try;
            root_reg <= {root_reg[RTW-2:0], fits};
            step_reg <= step_reg + STW'(1);
        end
        if (load_out) begin
            out_mag_reg <= mag_sat;
            out_rl_reg  <= rl_reg;
            out_fl_reg  <= fl_reg;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign m_magnitude  = out_mag_reg;
    assign m_row_last   = out_rl_reg;
    assign m_frame_last = out_fl_reg;

`ifndef SYNTHESIS
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROOT) |-> (step_reg < STW'(sem_pkg::ROOT_STEPS)))
        else $error("root step count out of range");

    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_valid_reg && !m_tready) |=> (state_reg == ST_DONE))
        else $error("result dropped while output register busy");
`endif

endmodule

`default_nettype wire
